### design/srg_pkg.sv
// ----------------------------------------------------------------------------
// srg_pkg: shared definitions of the stepper trapezoid ramp generator
// Widths, reset values, codes, state types and the controller/datapath bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package srg_pkg;

	localparam int DELAY_BITS    = 16;
	localparam int WORD_W        = 32;
	localparam int RATE_W        = 16;
	localparam int PULSE_DELAY_W = 16;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 32;
	localparam int S_TDATA_W     = 40;
	localparam int S_TUSER_W     = 2;
	localparam int M_TDATA_W     = 56;
	localparam int DIV_CNT_W     = $clog2(WORD_W + 1);

	localparam int unsigned FIRST_DELAY_TICKS = 1000;
	localparam int unsigned MIN_DELAY_TICKS   = 50;

	typedef logic [DELAY_BITS-1:0]    delay_t;
	typedef logic [WORD_W-1:0]        word_t;
	typedef logic [RATE_W-1:0]        rate_t;
	typedef logic [PULSE_DELAY_W-1:0] pdelay_t;

	localparam rate_t  FIRST_DELAY_RST   = rate_t'(FIRST_DELAY_TICKS);
	localparam rate_t  MIN_DELAY_RST     = rate_t'(MIN_DELAY_TICKS);
	localparam rate_t  MIN_DELAY_FLOOR   = rate_t'(MIN_DELAY_TICKS);
	localparam delay_t SINGLE_STEP_DELAY = delay_t'(FIRST_DELAY_TICKS);
	localparam word_t  ACCEL_STEPS_RST   = word_t'(1);
	localparam rate_t  RATE_RST          = rate_t'(1);

	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DELAY = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_DELAY   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_STEPS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_RATE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DECEL_RATE  = 3'd4;

	typedef enum logic [1:0] {
		MODE_TICK   = 2'd0,
		MODE_MOVE   = 2'd1,
		MODE_SENSOR = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		PH_STOP = 2'd0,
		PH_ACC  = 2'd1,
		PH_UNI  = 2'd2,
		PH_DEC  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		SENS_NORMAL  = 2'd0,
		SENS_ORIGIN  = 2'd1,
		SENS_LIM_POS = 2'd2,
		SENS_LIM_NEG = 2'd3
	} sensor_t;

	typedef enum logic [1:0] {
		DIV_RAMP  = 2'd0,
		DIV_SPLIT = 2'd1,
		DIV_DECEL = 2'd2
	} div_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_TICK_WAIT,
		ST_MOVE_MUL1,
		ST_MOVE_DIV1,
		ST_MOVE_WAIT1,
		ST_MOVE_SPLIT,
		ST_MOVE_MUL2,
		ST_MOVE_DIV2,
		ST_MOVE_WAIT2,
		ST_COMMIT
	} ctrl_state_t;

	typedef struct packed {
		logic     load_in;
		logic     mul_split;
		logic     mul_decel;
		logic     div_start;
		div_sel_t div_sel;
		logic     save_split;
		logic     commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       steps_small;
		logic       tick_div;
		logic       split_le_acc;
		logic       out_free;
	} dp_status_t;

endpackage

`default_nettype wire

### design/srg_div.sv
// ----------------------------------------------------------------------------
// srg_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, quotient and remainder held.
// ----------------------------------------------------------------------------
`default_nettype none

module srg_div import srg_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	input  wire word_t num,
	input  wire word_t den,
	output logic       busy,
	output word_t      quo,
	output word_t      rem
);

	word_t                quo_q;
	word_t                rem_q;
	word_t                den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [WORD_W:0]      shifted;
	logic [WORD_W:0]      diff;

	assign shifted = {rem_q, quo_q[WORD_W-1]};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= DIV_CNT_W'(WORD_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (cnt_q != '0) begin
			if (!diff[WORD_W]) begin
				rem_q <= diff[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

### design/srg_ctrl.sv
// ----------------------------------------------------------------------------
// srg_ctrl: sequencing controller of the ramp generator
// Accepts one item, steps the datapath through multiply and divide, commits.
// ----------------------------------------------------------------------------
`default_nettype none

module srg_ctrl import srg_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            in_ready,
	input  wire dp_status_t status,
	input  wire logic       div_busy,
	output ctrl_cmd_t       cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		cmd.div_sel = DIV_RAMP;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_nx    = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (status.mode)
					MODE_TICK: begin
						if (status.tick_div) begin
							cmd.div_start = 1'b1;
							cmd.div_sel   = DIV_RAMP;
							state_nx      = ST_TICK_WAIT;
						end else begin
							state_nx = ST_COMMIT;
						end
					end
					MODE_MOVE: begin
						state_nx = status.steps_small ? ST_COMMIT : ST_MOVE_MUL1;
					end
					default: begin
						state_nx = ST_COMMIT;
					end
				endcase
			end
			ST_TICK_WAIT: begin
				cmd.div_sel = DIV_RAMP;
				if (!div_busy) begin
					state_nx = ST_COMMIT;
				end
			end
			ST_MOVE_MUL1: begin
				cmd.mul_split = 1'b1;
				state_nx      = ST_MOVE_DIV1;
			end
			ST_MOVE_DIV1: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_SPLIT;
				state_nx      = ST_MOVE_WAIT1;
			end
			ST_MOVE_WAIT1: begin
				cmd.div_sel = DIV_SPLIT;
				if (!div_busy) begin
					state_nx = ST_MOVE_SPLIT;
				end
			end
			ST_MOVE_SPLIT: begin
				cmd.div_sel    = DIV_SPLIT;
				cmd.save_split = 1'b1;
				state_nx       = status.split_le_acc ? ST_COMMIT : ST_MOVE_MUL2;
			end
			ST_MOVE_MUL2: begin
				cmd.mul_decel = 1'b1;
				state_nx      = ST_MOVE_DIV2;
			end
			ST_MOVE_DIV2: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_DECEL;
				state_nx      = ST_MOVE_WAIT2;
			end
			ST_MOVE_WAIT2: begin
				cmd.div_sel = DIV_DECEL;
				if (!div_busy) begin
					state_nx = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (status.out_free) begin
					cmd.commit = 1'b1;
					state_nx   = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### design/srg_datapath.sv
// ----------------------------------------------------------------------------
// srg_datapath: motion state, configuration and result register
// Holds the ramp state, forms divider operands and applies each item's update.
// ----------------------------------------------------------------------------
`default_nettype none

module srg_datapath import srg_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire ctrl_cmd_t             cmd,
	output dp_status_t                 status,
	input  wire logic [S_TDATA_W-1:0]  s_tdata,
	input  wire logic [S_TUSER_W-1:0]  s_tuser,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output word_t                      div_num,
	output word_t                      div_den,
	input  wire word_t                 div_quo,
	input  wire word_t                 div_rem,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [M_TDATA_W-1:0]       m_tdata
);

	rate_t   first_delay_q;
	rate_t   min_delay_q;
	word_t   accel_steps_q;
	rate_t   accel_rate_q;
	rate_t   decel_rate_q;

	phase_t  phase_q;
	logic    dir_neg_q;
	word_t   decel_start_q;
	delay_t  cur_delay_q;
	word_t   decel_count_q;
	word_t   ramp_idx_q;
	word_t   steps_done_q;
	word_t   ramp_rem_q;
	pdelay_t cruise_delay_q;
	word_t   position_q;
	rate_t   eff_min_q;
	logic    lim_pos_q;
	logic    lim_neg_q;
	logic    stop_q;
	sensor_t sensor_q;

	logic [1:0] in_mode_q;
	word_t      in_steps_q;
	logic       in_origin_q;
	logic       in_lim_pos_q;
	logic       in_lim_neg_q;

	word_t   prod_q;
	word_t   split_q;

	logic                 out_valid_q;
	logic [M_TDATA_W-1:0] out_data_q;

	word_t   steps_abs;
	word_t   acc_eff;
	word_t   rate_sum;
	word_t   split_nx;
	word_t   decel_quo;
	word_t   ridx_inc;
	word_t   ramp_num;
	word_t   ramp_den;
	logic    num_neg;
	logic    den_neg;
	word_t   num_mag;
	word_t   den_mag;
	word_t   ramp_quo;
	word_t   ramp_rmd;
	delay_t  ramp_next;
	word_t   steps_inc;
	word_t   pos_step;
	logic    lim_hit;
	phase_t  tick_phase;
	word_t   dc_tmp;

	phase_t  nx_phase;
	logic    nx_dir_neg;
	word_t   nx_decel_start;
	delay_t  nx_cur_delay;
	word_t   nx_decel_count;
	word_t   nx_ramp_idx;
	word_t   nx_steps_done;
	word_t   nx_ramp_rem;
	pdelay_t nx_cruise_delay;
	word_t   nx_position;
	rate_t   nx_eff_min;
	logic    nx_lim_pos;
	logic    nx_lim_neg;
	logic    nx_stop;
	sensor_t nx_sensor;
	logic    res_pulse;
	pdelay_t res_pdelay;

	assign steps_abs = in_steps_q[WORD_W-1] ? (~in_steps_q + word_t'(1)) : in_steps_q;
	assign acc_eff   = (accel_steps_q == '0) ? word_t'(1) : accel_steps_q;
	assign rate_sum  = word_t'(accel_rate_q) + word_t'(decel_rate_q);
	assign split_nx  = ((rate_sum == '0) || (div_quo == '0)) ? word_t'(1) : div_quo;
	assign decel_quo = (decel_rate_q == '0) ? '0 : div_quo;

	assign ridx_inc  = ramp_idx_q + word_t'(1);
	assign ramp_num  = (word_t'(cur_delay_q) << 1) + ramp_rem_q;
	assign ramp_den  = (ridx_inc << 2) + word_t'(1);
	assign num_neg   = ramp_num[WORD_W-1];
	assign den_neg   = ramp_den[WORD_W-1];
	assign num_mag   = num_neg ? (~ramp_num + word_t'(1)) : ramp_num;
	assign den_mag   = den_neg ? (~ramp_den + word_t'(1)) : ramp_den;
	assign ramp_quo  = (num_neg ^ den_neg) ? (~div_quo + word_t'(1)) : div_quo;
	assign ramp_rmd  = num_neg ? (~div_rem + word_t'(1)) : div_rem;
	assign ramp_next = delay_t'(word_t'(cur_delay_q) - ramp_quo);

	assign steps_inc  = steps_done_q + word_t'(1);
	assign pos_step   = dir_neg_q ? '1 : word_t'(1);
	assign lim_hit    = dir_neg_q ? lim_neg_q : lim_pos_q;
	assign tick_phase = lim_hit ? PH_STOP : phase_q;

	always_comb begin
		div_num = prod_q;
		div_den = rate_sum;
		case (cmd.div_sel)
			DIV_RAMP: begin
				div_num = num_mag;
				div_den = den_mag;
			end
			DIV_SPLIT: begin
				div_num = prod_q;
				div_den = rate_sum;
			end
			DIV_DECEL: begin
				div_num = prod_q;
				div_den = word_t'(decel_rate_q);
			end
			default: begin
				div_num = prod_q;
				div_den = rate_sum;
			end
		endcase
	end

	always_comb begin
		status.mode         = in_mode_q;
		status.steps_small  = (steps_abs <= word_t'(1));
		status.tick_div     = (tick_phase == PH_ACC) || (tick_phase == PH_DEC);
		status.split_le_acc = (split_nx <= acc_eff);
		status.out_free     = !out_valid_q || m_tready;
	end

	always_comb begin
		nx_phase        = phase_q;
		nx_dir_neg      = dir_neg_q;
		nx_decel_start  = decel_start_q;
		nx_cur_delay    = cur_delay_q;
		nx_decel_count  = decel_count_q;
		nx_ramp_idx     = ramp_idx_q;
		nx_steps_done   = steps_done_q;
		nx_ramp_rem     = ramp_rem_q;
		nx_cruise_delay = cruise_delay_q;
		nx_position     = position_q;
		nx_eff_min      = eff_min_q;
		nx_lim_pos      = lim_pos_q;
		nx_lim_neg      = lim_neg_q;
		nx_stop         = stop_q;
		nx_sensor       = sensor_q;
		res_pulse       = 1'b0;
		res_pdelay      = '0;
		dc_tmp          = '0;
		case (in_mode_q)
			MODE_TICK: begin
				if (phase_q != PH_STOP) begin
					res_pulse  = 1'b1;
					res_pdelay = pdelay_t'(cur_delay_q);
				end
				if (!lim_hit) begin
					nx_lim_pos = 1'b0;
					nx_lim_neg = 1'b0;
				end
				nx_phase = tick_phase;
				case (tick_phase)
					PH_STOP: begin
						nx_stop         = 1'b1;
						nx_steps_done   = '0;
						nx_ramp_rem     = '0;
						nx_cruise_delay = '0;
						nx_cur_delay    = '0;
					end
					PH_ACC: begin
						nx_steps_done = steps_inc;
						nx_position   = position_q + pos_step;
						nx_ramp_idx   = ridx_inc;
						nx_ramp_rem   = ramp_rmd;
						nx_cur_delay  = ramp_next;
						if (steps_inc >= decel_start_q) begin
							nx_ramp_idx = decel_count_q;
							nx_phase    = PH_DEC;
						end else if (word_t'(ramp_next) <= word_t'(eff_min_q)) begin
							nx_cruise_delay = pdelay_t'(ramp_next);
							nx_cur_delay    = delay_t'(eff_min_q);
							nx_ramp_rem     = '0;
							nx_phase        = PH_UNI;
						end
					end
					PH_UNI: begin
						nx_steps_done = steps_inc;
						nx_position   = position_q + pos_step;
						nx_cur_delay  = delay_t'(eff_min_q);
						if (steps_inc >= decel_start_q) begin
							nx_ramp_idx  = decel_count_q;
							nx_cur_delay = delay_t'(cruise_delay_q);
							nx_phase     = PH_DEC;
						end
					end
					default: begin
						nx_steps_done = steps_inc;
						nx_position   = position_q + pos_step;
						nx_ramp_idx   = ridx_inc;
						nx_ramp_rem   = ramp_rmd;
						nx_cur_delay  = ramp_next;
						if (!ridx_inc[WORD_W-1]) begin
							nx_phase = PH_STOP;
						end
					end
				endcase
			end
			MODE_MOVE: begin
				nx_dir_neg = in_steps_q[WORD_W-1];
				if (steps_abs == word_t'(1)) begin
					nx_ramp_idx  = '1;
					nx_phase     = PH_DEC;
					nx_cur_delay = SINGLE_STEP_DELAY;
				end else if (steps_abs != '0) begin
					if (split_q <= acc_eff) begin
						dc_tmp = split_q - steps_abs;
					end else begin
						dc_tmp = ~decel_quo + word_t'(1);
					end
					if (dc_tmp == '0) begin
						dc_tmp = '1;
					end
					nx_decel_count = dc_tmp;
					nx_decel_start = steps_abs + dc_tmp;
					nx_eff_min     = min_delay_q;
					if (word_t'(delay_t'(first_delay_q)) <= word_t'(min_delay_q)) begin
						nx_cur_delay = delay_t'(min_delay_q);
						nx_phase     = PH_UNI;
					end else begin
						nx_cur_delay = delay_t'(first_delay_q);
						nx_phase     = PH_ACC;
					end
					nx_ramp_idx = '0;
				end
				nx_stop = 1'b0;
				if (nx_eff_min <= MIN_DELAY_FLOOR) begin
					nx_eff_min = MIN_DELAY_FLOOR;
				end
			end
			MODE_SENSOR: begin
				if (in_origin_q) begin
					nx_sensor = SENS_ORIGIN;
				end else if (in_lim_pos_q) begin
					nx_sensor  = SENS_LIM_POS;
					nx_lim_pos = 1'b1;
					nx_phase   = PH_STOP;
				end else if (in_lim_neg_q) begin
					nx_sensor  = SENS_LIM_NEG;
					nx_lim_neg = 1'b1;
					nx_phase   = PH_STOP;
				end else begin
					nx_sensor = SENS_NORMAL;
				end
			end
			default: begin
				nx_phase = phase_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_delay_q <= FIRST_DELAY_RST;
			min_delay_q   <= MIN_DELAY_RST;
			accel_steps_q <= ACCEL_STEPS_RST;
			accel_rate_q  <= RATE_RST;
			decel_rate_q  <= RATE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FIRST_DELAY: first_delay_q <= cfg_data[RATE_W-1:0];
				CFG_MIN_DELAY:   min_delay_q   <= cfg_data[RATE_W-1:0];
				CFG_ACCEL_STEPS: accel_steps_q <= cfg_data[WORD_W-1:0];
				CFG_ACCEL_RATE:  accel_rate_q  <= cfg_data[RATE_W-1:0];
				CFG_DECEL_RATE:  decel_rate_q  <= cfg_data[RATE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_STOP;
			dir_neg_q      <= 1'b0;
			decel_start_q  <= '0;
			cur_delay_q    <= '0;
			decel_count_q  <= '0;
			ramp_idx_q     <= '0;
			steps_done_q   <= '0;
			ramp_rem_q     <= '0;
			cruise_delay_q <= '0;
			position_q     <= '0;
			eff_min_q      <= '0;
			lim_pos_q      <= 1'b0;
			lim_neg_q      <= 1'b0;
			stop_q         <= 1'b0;
			sensor_q       <= SENS_NORMAL;
		end else if (cmd.commit) begin
			phase_q        <= nx_phase;
			dir_neg_q      <= nx_dir_neg;
			decel_start_q  <= nx_decel_start;
			cur_delay_q    <= nx_cur_delay;
			decel_count_q  <= nx_decel_count;
			ramp_idx_q     <= nx_ramp_idx;
			steps_done_q   <= nx_steps_done;
			ramp_rem_q     <= nx_ramp_rem;
			cruise_delay_q <= nx_cruise_delay;
			position_q     <= nx_position;
			eff_min_q      <= nx_eff_min;
			lim_pos_q      <= nx_lim_pos;
			lim_neg_q      <= nx_lim_neg;
			stop_q         <= nx_stop;
			sensor_q       <= nx_sensor;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_mode_q    <= s_tuser[1:0];
			in_steps_q   <= s_tdata[WORD_W-1:0];
			in_origin_q  <= s_tdata[WORD_W];
			in_lim_pos_q <= s_tdata[WORD_W+1];
			in_lim_neg_q <= s_tdata[WORD_W+2];
		end
		if (cmd.mul_split) begin
			prod_q <= word_t'(steps_abs * word_t'(decel_rate_q));
		end else if (cmd.mul_decel) begin
			prod_q <= word_t'(acc_eff * word_t'(accel_rate_q));
		end
		if (cmd.save_split) begin
			split_q <= split_nx;
		end
		if (cmd.commit) begin
			out_data_q <= {1'b0, nx_sensor, nx_stop, nx_phase, nx_position, nx_dir_neg,
				res_pdelay, res_pulse};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire

### design/stepper_trapezoid_ramp_generator.sv
// ----------------------------------------------------------------------------
// stepper_trapezoid_ramp_generator: one-axis stepper linear speed ramp
// Plans trapezoid or triangle moves and issues at most one step per tick item.
//
// Channel   Direction  Handshake                Contents
// s_*       in         s_tvalid / s_tready      item: mode in tuser, fields in tdata
// m_*       out        m_tvalid / m_tready      one result per item
// cfg_*     in         cfg_valid / cfg_ready    register index and write data
//
// A sensor, unknown, stopped or uniform tick item, or a move of at most one step,
// goes from dispatch straight to commit without using the divider.
// A ramp tick waits on the iterative divider before its commit.
// A longer move runs one multiply and divide, and a second pair when the split exceeds the accel steps.
// Reset clears the motion state and loads the register defaults.
// A result waits in the output register; the next item is accepted meanwhile,
// and its commit holds until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_trapezoid_ramp_generator import srg_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// move_steps[31:0], origin_seen[32], limit_pos_seen[33], limit_neg_seen[34], zero
	input  wire logic [S_TDATA_W-1:0]  s_tdata,
	// mode[1:0]
	input  wire logic [S_TUSER_W-1:0]  s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// pulse[0], pulse_delay[16:1], direction_negative[17], position[49:18],
	// motion_phase[51:50], stopped[52], sensor_code[54:53], zero
	output logic [M_TDATA_W-1:0]       m_tdata,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	ctrl_cmd_t  cmd;
	dp_status_t status;
	logic       div_busy;
	word_t      div_num;
	word_t      div_den;
	word_t      div_quo;
	word_t      div_rem;

	assign cfg_ready = 1'b1;

	srg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.div_busy (div_busy),
		.cmd      (cmd)
	);

	srg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	srg_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.div_num   (div_num),
		.div_den   (div_den),
		.div_quo   (div_quo),
		.div_rem   (div_rem),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

`default_nettype wire

### design/srg_checker.sv
// ----------------------------------------------------------------------------
// srg_checker: port-level checks of the ramp generator
// Watches the stream and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module srg_checker import srg_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_tvalid,
	input wire logic                  s_tready,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [M_TDATA_W-1:0]  m_tdata
);

	// A result that is not taken stays in place unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Items are worked one at a time, so an accepted transaction closes the input.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted again while an item is in work");

	// The stop flag is only ever set together with the stopped phase.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[52] |-> m_tdata[51:50] == PH_STOP)
		else $error("stop flag set outside the stopped phase");

	// Without a pulse the reported delay is zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[16:1] == 16'd0)
		else $error("pulse delay reported without a pulse");

endmodule

bind stepper_trapezoid_ramp_generator srg_checker u_srg_checker (.*);

`default_nettype wire
